### sv/codec_serial_register_writer_defines.svh
// Assertion macros for the serial register writer.
`ifndef CODEC_SERIAL_REGISTER_WRITER_DEFINES_SVH
`define CODEC_SERIAL_REGISTER_WRITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSRW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSRW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `CSRW_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define CSRW_ASSERT(label, clk, rst_n, prop, msg)
`define CSRW_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### sv/csrw_pkg.sv
`default_nettype none
package csrw_pkg;

    localparam int GPIO_WIDTH_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    // frame layout
    localparam int FRAME_WIDTH = 16;
    localparam logic [3:0] FRAME_MSB = 4'd15;
    localparam logic [7:0] WRITE_BIT = 8'h20;
    localparam logic [7:0] ADDR_MASK = 8'h1f;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_BITS         = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLEAR_BITS       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SELECT_MASK      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESELECT_PATTERN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_TRIGGER    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLOCK_PIN_MASK   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DATA_PIN_MASK    = 3'd6;

    // descriptor flags: plain select, pulse trigger
    localparam int DESC_FLAG_W = 2;

    typedef enum logic [2:0] {
        PH_CLK_LOW  = 3'b001,
        PH_DATA     = 3'b010,
        PH_CLK_HIGH = 3'b100
    } phase_t;

endpackage
`default_nettype wire

### sv/csrw_front.sv
`default_nettype none
module csrw_front
    import csrw_pkg::*;
#(
    parameter int GPIO_WIDTH = GPIO_WIDTH_DEF,
    parameter int DESC_W = GPIO_WIDTH + FRAME_WIDTH + DESC_FLAG_W
)(
    input  wire logic [GPIO_WIDTH-1:0] gpio_now,
    input  wire logic [1:0]            codec_addr,
    input  wire logic [GPIO_WIDTH-1:0] select_pattern,
    input  wire logic [7:0]            reg_addr,
    input  wire logic [7:0]            reg_data,
    input  wire logic [GPIO_WIDTH-1:0] set_bits,
    input  wire logic [GPIO_WIDTH-1:0] clear_bits,
    input  wire logic [GPIO_WIDTH-1:0] select_mask,
    input  wire logic                  pulse_trigger,
    output logic      [DESC_W-1:0]     desc
);

    logic [GPIO_WIDTH-1:0]  w0;
    logic [GPIO_WIDTH-1:0]  word;
    logic [FRAME_WIDTH-1:0] frame;
    logic [7:0]             hi_byte;
    logic                   plain;
    logic                   pulse;

    always_comb
    begin
        w0      = (gpio_now | set_bits) & ~clear_bits;
        plain   = (select_pattern == select_mask);
        pulse   = plain && pulse_trigger;
        hi_byte = {codec_addr, 6'd0} | WRITE_BIT | (reg_addr & ADDR_MASK);
        frame   = {hi_byte, reg_data};
        if (pulse)
        begin
            word = w0 | select_mask;
        end
        else if (plain)
        begin
            word = w0 & ~select_mask;
        end
        else
        begin
            word = (w0 & ~select_mask) | select_pattern;
        end
        desc = {word, frame, plain, pulse};
    end

endmodule
`default_nettype wire

### sv/csrw_fifo.sv
`default_nettype none
module csrw_fifo
    import csrw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  not_empty,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

endmodule
`default_nettype wire

### sv/csrw_back.sv
`default_nettype none
`include "codec_serial_register_writer_defines.svh"
module csrw_back
    import csrw_pkg::*;
#(
    parameter int GPIO_WIDTH = GPIO_WIDTH_DEF,
    parameter int DESC_W = GPIO_WIDTH + FRAME_WIDTH + DESC_FLAG_W
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire logic [DESC_W-1:0]     q_data,
    output logic                       pop,
    input  wire logic [GPIO_WIDTH-1:0] select_mask,
    input  wire logic [GPIO_WIDTH-1:0] deselect_pattern,
    input  wire logic [GPIO_WIDTH-1:0] clock_pin_mask,
    input  wire logic [GPIO_WIDTH-1:0] data_pin_mask,
    output logic      [GPIO_WIDTH-1:0] gpio_word,
    output logic                       word_valid,
    output logic                       last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_HEAD  = 5'b00010,
        ST_FRAME = 5'b00100,
        ST_PULSE = 5'b01000,
        ST_TAIL  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [3:0]             bit_reg, bit_next;
    logic [FRAME_WIDTH-1:0] frame_reg, frame_next;
    logic [GPIO_WIDTH-1:0]  w_reg, w_next;
    logic                   plain_reg, plain_next;
    logic                   pulse_reg, pulse_next;
    logic [GPIO_WIDTH-1:0]  gpio_word_reg, gpio_word_next;
    logic                   strobe_reg, strobe_next;
    logic                   last_reg, last_next;

    logic [GPIO_WIDTH-1:0]  q_word;
    logic [FRAME_WIDTH-1:0] q_frame;
    logic                   q_plain;
    logic                   q_pulse;
    logic                   load;
    logic [GPIO_WIDTH-1:0]  word;

    assign q_word  = q_data[DESC_W-1 -: GPIO_WIDTH];
    assign q_frame = q_data[FRAME_WIDTH+DESC_FLAG_W-1 -: FRAME_WIDTH];
    assign q_plain = q_data[1];
    assign q_pulse = q_data[0];

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        frame_next  = frame_reg;
        w_next      = w_reg;
        plain_next  = plain_reg;
        pulse_next  = pulse_reg;
        word        = w_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                load = q_valid;
            end
            ST_HEAD:
            begin
                strobe_next = 1'b1;
                state_next  = ST_FRAME;
            end
            ST_FRAME:
            begin
                strobe_next = 1'b1;
                case (phase_reg)
                    PH_CLK_LOW:
                    begin
                        word       = w_reg & ~clock_pin_mask;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        word       = frame_reg[FRAME_WIDTH-1] ? (w_reg | data_pin_mask)
                                                              : (w_reg & ~data_pin_mask);
                        phase_next = PH_CLK_HIGH;
                    end
                    PH_CLK_HIGH:
                    begin
                        word       = w_reg | clock_pin_mask;
                        phase_next = PH_CLK_LOW;
                        frame_next = {frame_reg[FRAME_WIDTH-2:0], 1'b0};
                        bit_next   = bit_reg - 4'd1;
                        if (bit_reg == '0)
                        begin
                            state_next = pulse_reg ? ST_PULSE : ST_TAIL;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CLK_LOW;
                    end
                endcase
                w_next = word;
            end
            ST_PULSE:
            begin
                word        = w_reg & ~select_mask;
                w_next      = word;
                strobe_next = 1'b1;
                state_next  = ST_TAIL;
            end
            ST_TAIL:
            begin
                word        = plain_reg ? (w_reg | select_mask)
                                        : ((w_reg & ~select_mask) | deselect_pattern);
                w_next      = word;
                strobe_next = 1'b1;
                last_next   = 1'b1;
                load        = q_valid;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            w_next     = q_word;
            frame_next = q_frame;
            plain_next = q_plain;
            pulse_next = q_pulse;
            bit_next   = FRAME_MSB;
            phase_next = PH_CLK_LOW;
            state_next = q_pulse ? ST_FRAME : ST_HEAD;
        end

        gpio_word_next = word;
        pop            = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_CLK_LOW;
            bit_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        w_reg         <= w_next;
        plain_reg     <= plain_next;
        pulse_reg     <= pulse_next;
        gpio_word_reg <= gpio_word_next;
    end

    assign gpio_word  = gpio_word_reg;
    assign word_valid = strobe_reg;
    assign last_word  = last_reg;

    `CSRW_ASSERT(a_pop_has_item, clk, rst_n, pop |-> q_valid, "pop from empty queue")
    `CSRW_ASSERT(a_tail_marks_last, clk, rst_n, (state_reg == ST_TAIL) |=> (last_word && word_valid), "tail word not marked last")
    `CSRW_ASSERT(a_last_from_tail, clk, rst_n, last_word |-> $past(state_reg == ST_TAIL), "last word outside tail")
    `CSRW_ASSERT(a_frame_stays, clk, rst_n, (state_reg == ST_FRAME && !(phase_reg == PH_CLK_HIGH && bit_reg == '0)) |=> (state_reg == ST_FRAME), "frame left early")

endmodule
`default_nettype wire

### sv/codec_serial_register_writer.sv
// Serial codec register writer. A write is accepted when start is high and busy is low;
// it produces exactly 50 GPIO words, one per clock cycle on consecutive cycles, each shown
// for one cycle with word_valid high and the 50th flagged by last_word. Results cannot be
// stalled. Writes are classified on entry and held in a two-entry queue while the word
// sequencer, which emits one word per cycle, plays out the current one; busy rises while
// the queue is full. The user must write the configuration registers through
// cfg_wr_en/cfg_addr/cfg_wdata only while no write is in progress; the block itself does
// not enforce this.
`default_nettype none
module codec_serial_register_writer
    import csrw_pkg::*;
#(
    parameter int GPIO_WIDTH = GPIO_WIDTH_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [GPIO_WIDTH-1:0] cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [GPIO_WIDTH-1:0] gpio_now,
    input  wire logic [1:0]            codec_addr,
    input  wire logic [GPIO_WIDTH-1:0] select_pattern,
    input  wire logic [7:0]            reg_addr,
    input  wire logic [7:0]            reg_data,
    output logic      [GPIO_WIDTH-1:0] gpio_word,
    output logic                       last_word,
    output logic                       word_valid
);

    localparam int DESC_W = GPIO_WIDTH + FRAME_WIDTH + DESC_FLAG_W;

    logic [GPIO_WIDTH-1:0] set_bits_reg;
    logic [GPIO_WIDTH-1:0] clear_bits_reg;
    logic [GPIO_WIDTH-1:0] select_mask_reg;
    logic [GPIO_WIDTH-1:0] deselect_pattern_reg;
    logic                  pulse_trigger_reg;
    logic [GPIO_WIDTH-1:0] clock_pin_mask_reg;
    logic [GPIO_WIDTH-1:0] data_pin_mask_reg;

    logic [DESC_W-1:0] desc;
    logic [DESC_W-1:0] q_data;
    logic              q_valid;
    logic              q_full;
    logic              pop;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg         <= '0;
            clear_bits_reg       <= '0;
            select_mask_reg      <= '0;
            deselect_pattern_reg <= '0;
            pulse_trigger_reg    <= 1'b0;
            clock_pin_mask_reg   <= '0;
            data_pin_mask_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_SET_BITS:         set_bits_reg         <= cfg_wdata;
                CFG_CLEAR_BITS:       clear_bits_reg       <= cfg_wdata;
                CFG_SELECT_MASK:      select_mask_reg      <= cfg_wdata;
                CFG_DESELECT_PATTERN: deselect_pattern_reg <= cfg_wdata;
                CFG_PULSE_TRIGGER:    pulse_trigger_reg    <= cfg_wdata[0];
                CFG_CLOCK_PIN_MASK:   clock_pin_mask_reg   <= cfg_wdata;
                CFG_DATA_PIN_MASK:    data_pin_mask_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign busy   = q_full;
    assign accept = start && !q_full;

    csrw_front #(
        .GPIO_WIDTH (GPIO_WIDTH),
        .DESC_W     (DESC_W)
    ) u_front (
        .gpio_now       (gpio_now),
        .codec_addr     (codec_addr),
        .select_pattern (select_pattern),
        .reg_addr       (reg_addr),
        .reg_data       (reg_data),
        .set_bits       (set_bits_reg),
        .clear_bits     (clear_bits_reg),
        .select_mask    (select_mask_reg),
        .pulse_trigger  (pulse_trigger_reg),
        .desc           (desc)
    );

    csrw_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .wr_data   (desc),
        .pop       (pop),
        .rd_data   (q_data),
        .not_empty (q_valid),
        .full      (q_full)
    );

    csrw_back #(
        .GPIO_WIDTH (GPIO_WIDTH),
        .DESC_W     (DESC_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .pop              (pop),
        .select_mask      (select_mask_reg),
        .deselect_pattern (deselect_pattern_reg),
        .clock_pin_mask   (clock_pin_mask_reg),
        .data_pin_mask    (data_pin_mask_reg),
        .gpio_word        (gpio_word),
        .word_valid       (word_valid),
        .last_word        (last_word)
    );

endmodule
`default_nettype wire

### tb/codec_serial_register_writer_test.sv
`timescale 1ns / 1ps

module codec_serial_register_writer_test;
    import csrw_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_NONE = 3'd7;

    typedef struct packed {
        logic [7:0] gpio_now;
        logic [1:0] codec_addr;
        logic [7:0] select_pattern;
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
    } codec_write_t;

    typedef struct packed {
        logic [7:0] gpio;
        logic       last;
    } gpio_out_t;

    class gpio_word_checker;
        logic [7:0] set_bits;
        logic [7:0] clear_bits;
        logic [7:0] select_mask;
        logic [7:0] deselect_pattern;
        logic       pulse_trigger;
        logic [7:0] clock_pin_mask;
        logic [7:0] data_pin_mask;
        gpio_out_t  pending_words[$];
        int         errors;

        function new();
            set_bits = '0;
            clear_bits = '0;
            select_mask = '0;
            deselect_pattern = '0;
            pulse_trigger = 1'b0;
            clock_pin_mask = '0;
            data_pin_mask = '0;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_SET_BITS:         set_bits = val;
                CFG_CLEAR_BITS:       clear_bits = val;
                CFG_SELECT_MASK:      select_mask = val;
                CFG_DESELECT_PATTERN: deselect_pattern = val;
                CFG_PULSE_TRIGGER:    pulse_trigger = val[0];
                CFG_CLOCK_PIN_MASK:   clock_pin_mask = val;
                CFG_DATA_PIN_MASK:    data_pin_mask = val;
                default:              ;
            endcase
        endfunction

        // expand one register write into the 50 GPIO words it should produce
        function void note_write(codec_write_t wr);
            logic [7:0]  w;
            logic [15:0] frame;
            logic        plain;
            w = (wr.gpio_now | set_bits) & ~clear_bits;
            plain = (wr.select_pattern == select_mask);
            if (plain)
            begin
                if (pulse_trigger)
                    w = w | select_mask;
                else
                begin
                    w = w & ~select_mask;
                    pending_words.push_back(gpio_out_t'{w, 1'b0});
                end
            end
            else
            begin
                w = (w & ~select_mask) | wr.select_pattern;
                pending_words.push_back(gpio_out_t'{w, 1'b0});
            end
            frame[15:8] = {wr.codec_addr, 6'b0} | WRITE_BIT | (wr.reg_addr & ADDR_MASK);
            frame[7:0] = wr.reg_data;
            for (int b = FRAME_WIDTH - 1; b >= 0; b--)
            begin
                w = w & ~clock_pin_mask;
                pending_words.push_back(gpio_out_t'{w, 1'b0});
                w = frame[b] ? (w | data_pin_mask) : (w & ~data_pin_mask);
                pending_words.push_back(gpio_out_t'{w, 1'b0});
                w = w | clock_pin_mask;
                pending_words.push_back(gpio_out_t'{w, 1'b0});
            end
            if (plain)
            begin
                if (pulse_trigger)
                begin
                    w = w & ~select_mask;
                    pending_words.push_back(gpio_out_t'{w, 1'b0});
                end
                w = w | select_mask;
            end
            else
                w = (w & ~select_mask) | deselect_pattern;
            pending_words.push_back(gpio_out_t'{w, 1'b1});
        endfunction

        function void check_word(logic [7:0] gpio, logic last);
            gpio_out_t exp_word;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word gpio=%02h last=%0b", gpio, last));
                return;
            end
            exp_word = pending_words.pop_front();
            if (gpio !== exp_word.gpio)
                report($sformatf("gpio_word %02h, expected %02h", gpio, exp_word.gpio));
            if (last !== exp_word.last)
                report($sformatf("last_word %0b, expected %0b", last, exp_word.last));
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [7:0]            cfg_wdata;
    logic                  start;
    logic                  busy;
    logic [7:0]            gpio_now;
    logic [1:0]            codec_addr;
    logic [7:0]            select_pattern;
    logic [7:0]            reg_addr;
    logic [7:0]            reg_data;
    logic [7:0]            gpio_word;
    logic                  last_word;
    logic                  word_valid;

    gpio_word_checker board;

    codec_serial_register_writer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .gpio_now       (gpio_now),
        .codec_addr     (codec_addr),
        .select_pattern (select_pattern),
        .reg_addr       (reg_addr),
        .reg_data       (reg_data),
        .gpio_word      (gpio_word),
        .last_word      (last_word),
        .word_valid     (word_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("codec_serial_register_writer_test: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && word_valid)
            board.check_word(gpio_word, last_word);
    end

    task write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task set_config(input logic [7:0] s, input logic [7:0] c, input logic [7:0] m,
                    input logic [7:0] d, input logic [7:0] p, input logic [7:0] ck,
                    input logic [7:0] dt);
        write_reg(CFG_SET_BITS, s);
        write_reg(CFG_CLEAR_BITS, c);
        write_reg(CFG_SELECT_MASK, m);
        write_reg(CFG_DESELECT_PATTERN, d);
        write_reg(CFG_PULSE_TRIGGER, p);
        write_reg(CFG_CLOCK_PIN_MASK, ck);
        write_reg(CFG_DATA_PIN_MASK, dt);
    endtask

    task send(input logic [7:0] g, input logic [1:0] ca, input logic [7:0] sp,
              input logic [7:0] ra, input logic [7:0] rd);
        codec_write_t wr;
        @(negedge clk);
        start = 1'b1;
        gpio_now = g;
        codec_addr = ca;
        select_pattern = sp;
        reg_addr = ra;
        reg_data = rd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        wr.gpio_now = g;
        wr.codec_addr = ca;
        wr.select_pattern = sp;
        wr.reg_addr = ra;
        wr.reg_data = rd;
        board.note_write(wr);
    endtask

    task pause(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task wait_drained();
        pause(1);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom);
        endcase
    endfunction

    task send_random(input bit idling);
        logic [7:0] sp;
        sp = ($urandom_range(0, 1) == 1) ? board.select_mask : 8'($urandom);
        send(8'($urandom), 2'($urandom), sp, 8'($urandom), 8'($urandom));
        if (idling && $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 8));
    endtask

    initial
    begin
        bit idling;
        board = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        start = 1'b0;
        gpio_now = '0;
        codec_addr = '0;
        select_pattern = '0;
        reg_addr = '0;
        reg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: a zero select pattern is plain select
        send(8'h00, 2'd0, 8'h00, 8'h00, 8'h00);
        send(8'hff, 2'd3, 8'hff, 8'hff, 8'hff);
        wait_drained();

        set_config(8'h01, 8'h02, 8'h0c, 8'h04, 8'h00, 8'h40, 8'h80);
        write_reg(CFG_NONE, 8'hff);
        send(8'h00, 2'd0, 8'h0c, 8'h1f, 8'h00);
        send(8'hff, 2'd1, 8'h0c, 8'he0, 8'hff);
        send(8'h5a, 2'd2, 8'h0c, 8'hff, 8'ha5);
        send(8'ha5, 2'd3, 8'h0c, 8'h00, 8'h5a);
        send(8'h33, 2'd1, 8'h08, 8'h15, 8'h81);
        send(8'hcc, 2'd2, 8'h00, 8'h0a, 8'h7e);
        send(8'h0f, 2'd3, 8'hff, 8'h1f, 8'hff);
        wait_drained();

        // select held high, pulse low after the frame
        set_config(8'h10, 8'h20, 8'h03, 8'h02, 8'hff, 8'h04, 8'h08);
        send(8'h00, 2'd0, 8'h03, 8'h11, 8'h22);
        send(8'hff, 2'd3, 8'h03, 8'hee, 8'hdd);
        send(8'h55, 2'd1, 8'h01, 8'h05, 8'hc3);
        wait_drained();

        // all masks overlapping
        set_config(8'hff, 8'hff, 8'hff, 8'hff, 8'h01, 8'hff, 8'hff);
        send(8'h00, 2'd2, 8'hff, 8'h1f, 8'h00);
        send(8'hff, 2'd1, 8'h7f, 8'h00, 8'hff);
        wait_drained();
        set_config(8'h00, 8'h00, 8'hf0, 8'h0f, 8'h00, 8'h0f, 8'h0f);
        send(8'h96, 2'd0, 8'hf0, 8'h1c, 8'h3c);
        send(8'h69, 2'd3, 8'h50, 8'h03, 8'hc3);
        wait_drained();

        for (int ph = 0; ph < 10; ph++)
        begin
            set_config(pick_mask(), pick_mask(), pick_mask(), pick_mask(),
                       8'($urandom), pick_mask(), pick_mask());
            idling = (ph < 9) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 46; i++)
            begin
                send_random(idling);
                if (ph == 2 && i == 20)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d words never arrived", board.pending()));
        if (board.errors == 0)
            $display("codec_serial_register_writer_test: PASS");
        else
            $display("codec_serial_register_writer_test: FAIL");
        $finish;
    end

endmodule
